// File: rtl/sliding_window_anagram_search_macros.svh
// Assertion macros used by the checker of the anagram search block.
`ifndef SLIDING_WINDOW_ANAGRAM_SEARCH_MACROS_SVH
`define SLIDING_WINDOW_ANAGRAM_SEARCH_MACROS_SVH

// Check a property on every rising edge outside reset.
`define SWAS_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check a property on every rising edge, reset included.
`define SWAS_ASSERT_ALWAYS(label, clk, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

// File: rtl/swas_pkg.sv
package swas_pkg;

	// Field widths of the letter and result beats
	localparam int MODE_W   = 2;
	localparam int LETTER_W = 5;
	localparam int POS_W    = 16;

	// Letters are indexed a=0 through z=25
	localparam int ALPHABET_SIZE = 26;
	localparam logic [LETTER_W-1:0] ALPHA_LIMIT = LETTER_W'(ALPHABET_SIZE);

	// Default sizes
	localparam int MAX_PATTERN_DEF = 256;
	localparam int MAX_TEXT_DEF    = 65536;

	// Mode codes of a letter beat; the fourth code is ignored
	localparam logic [MODE_W-1:0] MODE_CLEAR   = 2'd0;
	localparam logic [MODE_W-1:0] MODE_PATTERN = 2'd1;
	localparam logic [MODE_W-1:0] MODE_TEXT    = 2'd2;

	// Update commands from the sequencing logic to the count tables
	typedef struct packed {
		logic                clear;
		logic                pat_inc;
		logic                win_inc;
		logic                win_dec;
		logic [LETTER_W-1:0] letter;
		logic [LETTER_W-1:0] gone;
	} tbl_ctrl_t;

endpackage

// File: rtl/swas_if.sv
// Letter channel: one letter beat with its mode
interface swas_letter_if;
	logic                          valid;
	logic                          ready;
	logic [swas_pkg::MODE_W-1:0]   mode;
	logic [swas_pkg::LETTER_W-1:0] letter;

	modport source (output valid, mode, letter, input ready);
	modport sink (input valid, mode, letter, output ready);
endinterface

// Result channel: start of a window that matches the pattern
interface swas_pos_if;
	logic                       valid;
	logic                       ready;
	logic [swas_pkg::POS_W-1:0] start_position;

	modport source (output valid, start_position, input ready);
	modport sink (input valid, start_position, output ready);
endinterface

// File: rtl/swas_ram.sv
module swas_ram #(
	parameter int WIDTH = swas_pkg::LETTER_W,
	parameter int DEPTH = swas_pkg::MAX_PATTERN_DEF,
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write one word, read one word; a read of the word being written returns the old data
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: rtl/swas_tables.sv
module swas_tables #(
	parameter int MAX_PATTERN = swas_pkg::MAX_PATTERN_DEF
) (
	input  logic                clk,
	input  logic                arst_n,
	input  swas_pkg::tbl_ctrl_t ctrl,
	output logic                equal
);

	localparam int CNT_W = $clog2(MAX_PATTERN + 1);
	localparam int LW    = swas_pkg::LETTER_W;
	localparam int NL    = swas_pkg::ALPHABET_SIZE;

	logic [CNT_W-1:0] pat_q [NL];
	logic [CNT_W-1:0] win_q [NL];
	logic [CNT_W-1:0] pat_d [NL];
	logic [CNT_W-1:0] win_d [NL];

	// Work out each letter's next counts: drop the outgoing letter, then add the new one
	always_comb begin
		for (int k = 0; k < NL; k++) begin
			pat_d[k] = pat_q[k];
			win_d[k] = win_q[k];
			if (ctrl.pat_inc && ctrl.letter == LW'(k)) begin
				pat_d[k] = pat_q[k] + CNT_W'(1);
			end
			if (ctrl.win_dec && ctrl.gone == LW'(k) && win_q[k] != '0) begin
				win_d[k] = win_q[k] - CNT_W'(1);
			end
			if (ctrl.win_inc && ctrl.letter == LW'(k)) begin
				win_d[k] = win_d[k] + CNT_W'(1);
			end
		end
	end

	// Hold both tables; a clear empties them
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < NL; k++) begin
				pat_q[k] <= '0;
				win_q[k] <= '0;
			end
		end else if (ctrl.clear) begin
			for (int k = 0; k < NL; k++) begin
				pat_q[k] <= '0;
				win_q[k] <= '0;
			end
		end else begin
			for (int k = 0; k < NL; k++) begin
				pat_q[k] <= pat_d[k];
				win_q[k] <= win_d[k];
			end
		end
	end

	// Compare the stored tables letter by letter
	always_comb begin
		equal = 1'b1;
		for (int k = 0; k < NL; k++) begin
			if (pat_q[k] != win_q[k]) begin
				equal = 1'b0;
			end
		end
	end

endmodule

// File: rtl/sliding_window_anagram_search.sv
// Sliding-window anagram search. Each letter beat carries a mode: clear empties every table
// and counter, pattern loads one letter into the pattern count table (only before the first
// text letter, up to MAX_PATTERN letters), text feeds one letter of the searched text (up to
// MAX_TEXT letters). Letters at or above 26 and the unused mode are dropped. When the window of
// the last pattern-length text letters holds the same letters as the pattern, one beat gives
// the window's start position, low 16 bits. An empty pattern never matches. The block takes one
// letter beat every cycle while input ready is high; the text letter that completes the window
// passes stage 1 and the stage-2 compare before its result queues in a two-entry output buffer,
// and input ready drops only while both entries are full, a further candidate waits in the
// compare stage and the sink does not take a beat. The ring of recent text letters is one
// MAX_PATTERN-entry RAM; its read for a letter is issued in the cycle the letter is accepted.
module sliding_window_anagram_search #(
	parameter int MAX_PATTERN = swas_pkg::MAX_PATTERN_DEF,
	parameter int MAX_TEXT    = swas_pkg::MAX_TEXT_DEF
) (
	input  logic             clk,
	input  logic             arst_n,
	swas_letter_if.sink      letters,
	swas_pos_if.source       starts
);

	localparam int LEN_W  = $clog2(MAX_PATTERN + 1);
	localparam int TC_W   = $clog2(MAX_TEXT + 1);
	localparam int ADDR_W = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
	localparam int CMP_W  = (TC_W > LEN_W) ? TC_W : LEN_W;
	localparam int LW     = swas_pkg::LETTER_W;
	localparam int PW     = swas_pkg::POS_W;
	localparam int MW     = swas_pkg::MODE_W;

	function automatic logic [ADDR_W-1:0] ptr_inc(input logic [ADDR_W-1:0] p);
		if (p == ADDR_W'(MAX_PATTERN - 1)) begin
			return '0;
		end
		return p + ADDR_W'(1);
	endfunction

	// Stage 1: the accepted beat
	logic          valid_s1;
	logic [MW-1:0] mode_s1;
	logic [LW-1:0] letter_s1;

	// Search state
	logic [LEN_W-1:0]  len_q;
	logic [TC_W-1:0]   tc_q;
	logic [ADDR_W-1:0] wp_q;
	logic [ADDR_W-1:0] rp_q;
	logic              byp_q;
	logic [LW-1:0]     byp_letter_q;

	// Stage 2: candidate window waiting for the table compare
	logic          cand_s2;
	logic [PW-1:0] pos_s2;

	// Output buffer
	logic          v0_q, v1_q;
	logic [PW-1:0] d0_q, d1_q;
	logic          v0_d, v1_d;
	logic [PW-1:0] d0_d, d1_d;

	logic              advance, pop, push, equal;
	logic              is_clear, letter_ok, pat_ok, text_ok, have_pat, evict, hit;
	logic [CMP_W-1:0]  tc_ext, tc_inc_ext, len_ext;
	logic [PW-1:0]     pos_d;
	logic [LEN_W-1:0]  len_nxt;
	logic [TC_W-1:0]   tc_nxt;
	logic [ADDR_W-1:0] wp_nxt, rp_nxt, ram_raddr;
	logic [LW-1:0]     ram_rdata, gone;
	swas_pkg::tbl_ctrl_t ctrl;

	// Move the pipeline unless a candidate has nowhere to go
	assign pop           = v0_q && starts.ready;
	assign advance       = !(cand_s2 && v1_q && !pop);
	assign push          = advance && cand_s2 && equal;
	assign letters.ready = advance;

	// Decode the beat in stage 1
	assign letter_ok = letter_s1 < swas_pkg::ALPHA_LIMIT;
	assign is_clear  = valid_s1 && mode_s1 == swas_pkg::MODE_CLEAR;
	assign pat_ok    = valid_s1 && mode_s1 == swas_pkg::MODE_PATTERN && letter_ok
		&& tc_q == '0 && len_q < LEN_W'(MAX_PATTERN);
	assign text_ok   = valid_s1 && mode_s1 == swas_pkg::MODE_TEXT && letter_ok
		&& tc_q < TC_W'(MAX_TEXT);
	assign have_pat  = len_q != '0;

	// Window position arithmetic
	assign tc_ext     = CMP_W'(tc_q);
	assign tc_inc_ext = tc_ext + CMP_W'(1);
	assign len_ext    = CMP_W'(len_q);
	assign evict      = text_ok && have_pat && tc_ext >= len_ext;
	assign hit        = text_ok && have_pat && tc_inc_ext >= len_ext;
	assign pos_d      = PW'(tc_inc_ext - len_ext);

	// Next counters and ring pointers
	assign len_nxt = is_clear ? '0 : len_q + LEN_W'(pat_ok);
	assign tc_nxt  = is_clear ? '0 : tc_q + TC_W'(text_ok);
	assign wp_nxt  = is_clear ? '0 : (text_ok ? ptr_inc(wp_q) : wp_q);
	assign rp_nxt  = is_clear ? '0 : (evict ? ptr_inc(rp_q) : rp_q);

	// Read the outgoing letter for the next beat; re-read the held one while stalled
	assign ram_raddr = advance ? rp_nxt : rp_q;
	assign gone      = byp_q ? byp_letter_q : ram_rdata;

	swas_ram #(
		.WIDTH (LW),
		.DEPTH (MAX_PATTERN)
	) u_ring (
		.clk   (clk),
		.we    (advance && text_ok),
		.waddr (wp_q),
		.wdata (letter_s1),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	// Table updates, gated by pipeline advance
	always_comb begin
		ctrl.clear   = advance && is_clear;
		ctrl.pat_inc = advance && pat_ok;
		ctrl.win_inc = advance && text_ok && have_pat;
		ctrl.win_dec = advance && evict;
		ctrl.letter  = letter_s1;
		ctrl.gone    = gone;
	end

	swas_tables #(
		.MAX_PATTERN (MAX_PATTERN)
	) u_tables (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.equal  (equal)
	);

	// Pop the head, then push the new result behind what is left
	always_comb begin
		v0_d = v0_q;
		v1_d = v1_q;
		d0_d = d0_q;
		d1_d = d1_q;
		if (pop) begin
			v0_d = v1_q;
			d0_d = d1_q;
			v1_d = 1'b0;
		end
		if (push) begin
			if (!v0_d) begin
				v0_d = 1'b1;
				d0_d = pos_s2;
			end else begin
				v1_d = 1'b1;
				d1_d = pos_s2;
			end
		end
	end

	assign starts.valid          = v0_q;
	assign starts.start_position = d0_q;

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			len_q    <= '0;
			tc_q     <= '0;
			wp_q     <= '0;
			rp_q     <= '0;
			byp_q    <= 1'b0;
			cand_s2  <= 1'b0;
			v0_q     <= 1'b0;
			v1_q     <= 1'b0;
		end else begin
			v0_q <= v0_d;
			v1_q <= v1_d;
			byp_q <= advance && text_ok && wp_q == rp_nxt;
			if (advance) begin
				valid_s1 <= letters.valid;
				len_q    <= len_nxt;
				tc_q     <= tc_nxt;
				wp_q     <= wp_nxt;
				rp_q     <= rp_nxt;
				cand_s2  <= hit;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		d0_q <= d0_d;
		d1_q <= d1_d;
		byp_letter_q <= letter_s1;
		if (advance) begin
			mode_s1   <= letters.mode;
			letter_s1 <= letters.letter;
			pos_s2    <= pos_d;
		end
	end

endmodule

// File: rtl/swas_checker.sv
`include "sliding_window_anagram_search_macros.svh"

module swas_checker (
	input logic                       clk,
	input logic                       arst_n,
	input logic                       in_ready,
	input logic                       out_valid,
	input logic                       out_ready,
	input logic [swas_pkg::POS_W-1:0] out_pos
);

	// A stalled result beat holds
	`SWAS_ASSERT(a_out_hold, clk, arst_n, out_valid && !out_ready |=> out_valid && $stable(out_pos), "result beat changed while stalled")

	// Input back-pressure only while a result is waiting and not taken
	`SWAS_ASSERT(a_stall_cause, clk, arst_n, !in_ready |-> out_valid && !out_ready, "input stalled with no blocked result")

	// No result once reset has been seen at an edge
	`SWAS_ASSERT_ALWAYS(a_rst_quiet, clk, !arst_n |=> !out_valid, "result shown during reset")

	// Ready as soon as reset lifts
	`SWAS_ASSERT_ALWAYS(a_rst_ready, clk, $rose(arst_n) |-> in_ready, "input not ready after reset")

endmodule

bind sliding_window_anagram_search swas_checker u_swas_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (letters.ready),
	.out_valid (starts.valid),
	.out_ready (starts.ready),
	.out_pos   (starts.start_position)
);
